// ===== sv/rope_pkg.sv =====
package rope_pkg;

    // Field widths
    localparam int POS_W        = 12;
    localparam int IDX_W        = 6;
    localparam int VAL_W        = 16;
    localparam int SCALE_W      = 16;
    localparam int PHASE_W      = 40;
    localparam int ANG_W        = 31;
    localparam int TERM_W       = 32;
    localparam int ACC_W        = 35;

    // Geometry of the embedding
    localparam int HEAD_DIM     = 128;
    localparam int MAX_POSITION = 4096;
    localparam int TABLE_DEPTH  = 64;

    // Series length of the quarter-wave sine and cosine
    localparam int TERMS        = 10;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd16384;

    localparam logic [63:0] LN2_Q32        = 64'd2977044472;
    localparam logic [63:0] LOG2_10000_Q32 = 64'd57070290109;
    localparam logic [63:0] INV_TWO_PI_Q32 = 64'd683565276;
    localparam logic [63:0] HALF_PI_Q31    = 64'd3373259426;

    typedef logic [PHASE_W-1:0] phase_t;
    typedef phase_t freq_tab_t [TABLE_DEPTH];

    // 2^-f for f in Q32 [0,1), result in Q32; each term truncates
    function automatic logic [63:0] exp2_neg_frac(input logic [63:0] f);
        logic [63:0] y;
        logic [63:0] acc;
        logic [63:0] term;
        y    = ({32'b0, f[31:0]} * LN2_Q32) >> 32;
        acc  = 64'd1 << 32;
        term = 64'd1 << 32;
        term = ((term * y) >> 32) / 64'd1;  acc = acc - term;
        term = ((term * y) >> 32) / 64'd2;  acc = acc + term;
        term = ((term * y) >> 32) / 64'd3;  acc = acc - term;
        term = ((term * y) >> 32) / 64'd4;  acc = acc + term;
        term = ((term * y) >> 32) / 64'd5;  acc = acc - term;
        term = ((term * y) >> 32) / 64'd6;  acc = acc + term;
        term = ((term * y) >> 32) / 64'd7;  acc = acc - term;
        term = ((term * y) >> 32) / 64'd8;  acc = acc + term;
        term = ((term * y) >> 32) / 64'd9;  acc = acc - term;
        term = ((term * y) >> 32) / 64'd10; acc = acc + term;
        term = ((term * y) >> 32) / 64'd11; acc = acc - term;
        term = ((term * y) >> 32) / 64'd12; acc = acc + term;
        term = ((term * y) >> 32) / 64'd13; acc = acc - term;
        term = ((term * y) >> 32) / 64'd14; acc = acc + term;
        term = ((term * y) >> 32) / 64'd15; acc = acc - term;
        term = ((term * y) >> 32) / 64'd16; acc = acc + term;
        return acc;
    endfunction

    // Inverse frequency of pair k in turns per position, Q0.40
    function automatic phase_t table_entry(input int unsigned k);
        logic [63:0] e;
        logic [63:0] n;
        logic [63:0] m;
        if (2 * k >= HEAD_DIM) begin
            return '0;
        end
        e = (64'(2 * k) * LOG2_10000_Q32) / 64'(HEAD_DIM);
        n = e >> 32;
        if (n > 64'd39) begin
            return '0;
        end
        m = exp2_neg_frac({32'b0, e[31:0]});
        return PHASE_W'(((m * INV_TWO_PI_Q32) >> 24) >> n);
    endfunction

    function automatic freq_tab_t build_freq_table();
        freq_tab_t tab;
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            tab[k] = table_entry(k);
        end
        return tab;
    endfunction

    localparam freq_tab_t FREQ_TABLE = build_freq_table();

    // Term divisors of the sine and cosine series
    function automatic int unsigned sin_div(input int unsigned i);
        return (2 * i) * (2 * i + 1);
    endfunction

    function automatic int unsigned cos_div(input int unsigned i);
        return (2 * i - 1) * (2 * i);
    endfunction

endpackage

// ===== sv/rotary_embedding_cos_sin_top.sv =====
// Rotary position embedding cosine/sine generator.
//
// Requests: drive position and freq_index with start high; a request is
// taken at every rising edge where start is high and busy is low. busy
// stays low: the pipeline takes one request in every cycle, with no
// dependence between requests.
// Results: cos_value and sin_value are valid for exactly one cycle while
// done is high, in request order. The receiver cannot hold them off, and
// the pipeline never stalls.
// Pipeline: valid bits travel with the data to done. The ten-term
// quarter-wave series makes up most of it: each term spends one stage
// on its product with the squared angle and one on the division by its
// constant, done as a multiply by an exact reciprocal. Five stages in
// front form the phase and angle; three behind clamp, scale and round.
// Throughput: one request per cycle.
// Configuration: cfg_we with cfg_data writes attention_scale (unsigned
// Q2.14). Write it only while no request is in flight.
// Reset: attention_scale returns to 1.0 and all in-flight requests are
// dropped. The frequency table is a constant and needs no fill.
module rotary_embedding_cos_sin_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [rope_pkg::POS_W-1:0]        position,
    input  logic [rope_pkg::IDX_W-1:0]        freq_index,
    input  logic                              cfg_we,
    input  logic [rope_pkg::SCALE_W-1:0]      cfg_data,
    output logic                              done,
    output logic signed [rope_pkg::VAL_W-1:0] cos_value,
    output logic signed [rope_pkg::VAL_W-1:0] sin_value
);
    import rope_pkg::*;

    localparam int FRONT_STAGES = 5;
    localparam int BACK_STAGES  = 3;
    localparam int LATENCY      = FRONT_STAGES + 2 * TERMS + BACK_STAGES;
    localparam int MUL_W        = 2 * TERM_W + 1;
    localparam int PROD_W       = ANG_W + SCALE_W;
    localparam int ROUND_SH     = 30;
    localparam int P_W          = PROD_W + 1 - ROUND_SH;

    localparam logic [ANG_W-1:0] ONE_Q30 = ANG_W'(1) << ROUND_SH;
    localparam logic [P_W-1:0]   POS_MAX = P_W'((1 << (VAL_W - 1)) - 1);
    localparam logic [P_W-1:0]   NEG_MAX = P_W'(1 << (VAL_W - 1));

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    // Round half away from zero, then saturate to the signed output range
    function automatic logic [VAL_W-1:0] round_sat(input logic [PROD_W-1:0] prod,
                                                   input logic neg);
        logic [PROD_W:0] sum;
        logic [P_W-1:0]  p;
        sum = {1'b0, prod} + ((PROD_W + 1)'(1) << (ROUND_SH - 1));
        p   = P_W'(sum >> ROUND_SH);
        if (neg) begin
            if (p > NEG_MAX) begin
                p = NEG_MAX;
            end
            return VAL_W'(-p);
        end
        if (p > POS_MAX) begin
            p = POS_MAX;
        end
        return VAL_W'(p);
    endfunction

    logic                 accept;
    logic [LATENCY-1:0]   valid_reg;
    logic [LATENCY-1:0]   valid_next;
    logic [SCALE_W-1:0]   scale_reg;

    // Front stages
    logic [POS_W-1:0]     pos1_reg;
    logic [IDX_W-1:0]     k1_reg;
    logic [POS_W-1:0]     pos2_reg;
    phase_t               entry2_reg;
    phase_t               phase3_reg;
    logic [POS_W+PHASE_W-1:0] phase_prod;
    logic [1:0]           quad4_reg;
    logic [ANG_W-1:0]     a4_reg;
    logic [63:0]          ang_prod;
    logic [2*ANG_W-1:0]   a_sq;

    // Series boundaries (after each term) and mid-term registers
    logic [TERM_W-1:0]        ts_b  [0:TERMS];
    logic [TERM_W-1:0]        tc_b  [0:TERMS];
    logic signed [ACC_W-1:0]  ss_b  [0:TERMS];
    logic signed [ACC_W-1:0]  cc_b  [0:TERMS];
    logic [TERM_W-1:0]        a2_b  [0:TERMS];
    logic [1:0]               quad_b[0:TERMS];
    logic [TERM_W-1:0]        xs_a  [1:TERMS];
    logic [TERM_W-1:0]        xc_a  [1:TERMS];
    logic signed [ACC_W-1:0]  ssx_a [1:TERMS];
    logic signed [ACC_W-1:0]  ccx_a [1:TERMS];
    logic [TERM_W-1:0]        a2x_a [1:TERMS];
    logic [1:0]               quadx_a[1:TERMS];

    // Back stages
    logic signed [ACC_W-1:0]  s_sum;
    logic signed [ACC_W-1:0]  c_sum;
    logic [ANG_W-1:0]         s_clamp;
    logic [ANG_W-1:0]         c_clamp;
    logic [ANG_W-1:0]         s_c_reg;
    logic [ANG_W-1:0]         c_c_reg;
    logic [1:0]               quad_c_reg;
    logic [ANG_W-1:0]         cos_mag;
    logic [ANG_W-1:0]         sin_mag;
    logic                     cos_neg;
    logic                     sin_neg;
    logic [PROD_W-1:0]        cos_prod_reg;
    logic [PROD_W-1:0]        sin_prod_reg;
    logic                     cos_neg_reg;
    logic                     sin_neg_reg;
    logic [VAL_W-1:0]         cos_value_reg;
    logic [VAL_W-1:0]         sin_value_reg;

    assign busy       = 1'b0;
    assign accept     = start && !busy;
    assign valid_next = {valid_reg[LATENCY-2:0], accept};
    assign done       = valid_reg[LATENCY-1];
    assign cos_value  = cos_value_reg;
    assign sin_value  = sin_value_reg;

    // Valid bits travel with the data; reset drops everything in flight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            scale_reg <= SCALE_RESET;
        end
        else
        begin
            valid_reg <= valid_next;
            if (cfg_we)
            begin
                scale_reg <= cfg_data;
            end
        end
    end

    // Phase = position * inverse frequency, wrapped to one turn
    assign phase_prod = (POS_W + PHASE_W)'(pos2_reg) * (POS_W + PHASE_W)'(entry2_reg);
    // Angle within the quadrant, Q30 radians
    assign ang_prod   = 64'(phase3_reg[PHASE_W-3:6]) * HALF_PI_Q31;
    assign a_sq       = (2 * ANG_W)'(a4_reg) * (2 * ANG_W)'(a4_reg);

    always_ff @(posedge clk)
    begin
        pos1_reg   <= POS_W'(32'(position) % MAX_POSITION);
        k1_reg     <= freq_index;
        pos2_reg   <= pos1_reg;
        entry2_reg <= FREQ_TABLE[k1_reg];
        phase3_reg <= PHASE_W'(phase_prod);
        quad4_reg  <= phase3_reg[PHASE_W-1 -: 2];
        a4_reg     <= ANG_W'(ang_prod >> 33);
        // Seed the series: term zero is a for sine and one for cosine
        ts_b[0]    <= TERM_W'(a4_reg);
        tc_b[0]    <= TERM_W'(ONE_Q30);
        ss_b[0]    <= '0;
        cc_b[0]    <= '0;
        a2_b[0]    <= TERM_W'(a_sq >> ROUND_SH);
        quad_b[0]  <= quad4_reg;
    end

    // One term per pair of stages: multiply by a^2, then divide by the
    // term's constant through an exact reciprocal. The previous term is
    // folded into the running sum alongside the multiply.
    for (genvar gi = 1; gi <= TERMS; gi++)
    begin : g_term
        localparam int unsigned DS  = sin_div(gi);
        localparam int unsigned DC  = cos_div(gi);
        localparam int          SHS = TERM_W + $clog2(DS);
        localparam int          SHC = TERM_W + $clog2(DC);
        localparam logic [TERM_W:0] MS =
            (TERM_W + 1)'(((MUL_W'(1) << SHS) + MUL_W'(DS) - MUL_W'(1)) / MUL_W'(DS));
        localparam logic [TERM_W:0] MC =
            (TERM_W + 1)'(((MUL_W'(1) << SHC) + MUL_W'(DC) - MUL_W'(1)) / MUL_W'(DC));
        localparam bit PREV_ADD = ((gi - 1) % 2) == 0;

        logic [2*TERM_W-1:0]     ps;
        logic [2*TERM_W-1:0]     pc;
        logic [MUL_W-1:0]        qs;
        logic [MUL_W-1:0]        qc;
        logic signed [ACC_W-1:0] ts_ext;
        logic signed [ACC_W-1:0] tc_ext;

        assign ps     = (2 * TERM_W)'(ts_b[gi-1]) * (2 * TERM_W)'(a2_b[gi-1]);
        assign pc     = (2 * TERM_W)'(tc_b[gi-1]) * (2 * TERM_W)'(a2_b[gi-1]);
        assign qs     = MUL_W'(xs_a[gi]) * MUL_W'(MS);
        assign qc     = MUL_W'(xc_a[gi]) * MUL_W'(MC);
        assign ts_ext = $signed({{(ACC_W - TERM_W){1'b0}}, ts_b[gi-1]});
        assign tc_ext = $signed({{(ACC_W - TERM_W){1'b0}}, tc_b[gi-1]});

        always_ff @(posedge clk)
        begin
            xs_a[gi]    <= TERM_W'(ps >> ROUND_SH);
            xc_a[gi]    <= TERM_W'(pc >> ROUND_SH);
            ssx_a[gi]   <= PREV_ADD ? ss_b[gi-1] + ts_ext : ss_b[gi-1] - ts_ext;
            ccx_a[gi]   <= PREV_ADD ? cc_b[gi-1] + tc_ext : cc_b[gi-1] - tc_ext;
            a2x_a[gi]   <= a2_b[gi-1];
            quadx_a[gi] <= quad_b[gi-1];
            ts_b[gi]    <= TERM_W'(qs >> SHS);
            tc_b[gi]    <= TERM_W'(qc >> SHC);
            ss_b[gi]    <= ssx_a[gi];
            cc_b[gi]    <= ccx_a[gi];
            a2_b[gi]    <= a2x_a[gi];
            quad_b[gi]  <= quadx_a[gi];
        end
    end

    // Fold in the last term and clamp to [0, 1]
    always_comb
    begin
        if ((TERMS % 2) == 0)
        begin
            s_sum = ss_b[TERMS] + $signed({{(ACC_W - TERM_W){1'b0}}, ts_b[TERMS]});
            c_sum = cc_b[TERMS] + $signed({{(ACC_W - TERM_W){1'b0}}, tc_b[TERMS]});
        end
        else
        begin
            s_sum = ss_b[TERMS] - $signed({{(ACC_W - TERM_W){1'b0}}, ts_b[TERMS]});
            c_sum = cc_b[TERMS] - $signed({{(ACC_W - TERM_W){1'b0}}, tc_b[TERMS]});
        end
        priority if (s_sum < 0)
            s_clamp = '0;
        else if (s_sum > $signed({{(ACC_W - ANG_W){1'b0}}, ONE_Q30}))
            s_clamp = ONE_Q30;
        else
            s_clamp = ANG_W'(s_sum);
        priority if (c_sum < 0)
            c_clamp = '0;
        else if (c_sum > $signed({{(ACC_W - ANG_W){1'b0}}, ONE_Q30}))
            c_clamp = ONE_Q30;
        else
            c_clamp = ANG_W'(c_sum);
    end

    // Map the quarter-wave pair onto the quadrant
    always_comb
    begin
        unique case (quad_c_reg)
            QUAD_0:
            begin
                cos_mag = c_c_reg; cos_neg = 1'b0;
                sin_mag = s_c_reg; sin_neg = 1'b0;
            end
            QUAD_1:
            begin
                cos_mag = s_c_reg; cos_neg = 1'b1;
                sin_mag = c_c_reg; sin_neg = 1'b0;
            end
            QUAD_2:
            begin
                cos_mag = c_c_reg; cos_neg = 1'b1;
                sin_mag = s_c_reg; sin_neg = 1'b1;
            end
            QUAD_3:
            begin
                cos_mag = s_c_reg; cos_neg = 1'b0;
                sin_mag = c_c_reg; sin_neg = 1'b1;
            end
            default:
            begin
                cos_mag = c_c_reg; cos_neg = 1'b0;
                sin_mag = s_c_reg; sin_neg = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        s_c_reg       <= s_clamp;
        c_c_reg       <= c_clamp;
        quad_c_reg    <= quad_b[TERMS];
        cos_prod_reg  <= PROD_W'(cos_mag) * PROD_W'(scale_reg);
        sin_prod_reg  <= PROD_W'(sin_mag) * PROD_W'(scale_reg);
        cos_neg_reg   <= cos_neg;
        sin_neg_reg   <= sin_neg;
        cos_value_reg <= round_sat(cos_prod_reg, cos_neg_reg);
        sin_value_reg <= round_sat(sin_prod_reg, sin_neg_reg);
    end

    // Every accepted request yields its result once it has passed through the pipeline
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("result missing after pipeline latency");

    // At unit scale the outputs never exceed one in magnitude
    a_unit_scale: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(scale_reg, 2) == SCALE_RESET) |->
        (cos_value <= 16384 && cos_value >= -16384 &&
         sin_value <= 16384 && sin_value >= -16384))
        else $error("output exceeds unit magnitude at unit scale");

    // A zero scale forces both outputs to zero
    a_zero_scale: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(scale_reg, 2) == '0) |-> (cos_value == 0 && sin_value == 0))
        else $error("nonzero output at zero scale");

endmodule
